@@ design/mffp_pkg.sv @@
`default_nettype none
package mffp_pkg;
    localparam int SIDE_BITS = 4;
    localparam int CELL_BITS = 2 * SIDE_BITS;
    localparam int CELLS = 1 << CELL_BITS;
    localparam int DIST_BITS = 10;
    localparam int QCNT_BITS = CELL_BITS + 1;
    localparam int POP_BITS = CELL_BITS + 4;
    localparam logic [DIST_BITS-1:0] UNREACHED = 10'd999;
    localparam logic [DIST_BITS-1:0] MAX_DIST = 10'd998;
    localparam logic [DIST_BITS-1:0] NO_CELL = 10'd1023;

    localparam logic [1:0] KIND_WALLS = 2'd0;
    localparam logic [1:0] KIND_FILL = 2'd1;
    localparam logic [1:0] KIND_READ = 2'd2;
    localparam logic [1:0] KIND_MOVE = 2'd3;

    localparam logic [2:0] MOVE_FWD = 3'd0;
    localparam logic [2:0] MOVE_LEFT = 3'd1;
    localparam logic [2:0] MOVE_BACKUP = 3'd2;
    localparam logic [2:0] MOVE_RIGHT = 3'd3;
    localparam logic [2:0] MOVE_ABOUT = 3'd4;

    localparam logic [1:0] REG_GOAL_COL = 2'd0;
    localparam logic [1:0] REG_GOAL_ROW = 2'd1;
    localparam logic [1:0] REG_GOAL_SQ = 2'd2;
    localparam logic [1:0] REG_BIAS = 2'd3;

    typedef struct packed {
        logic [1:0] kind;
        logic [3:0] cell_col;
        logic [3:0] cell_row;
        logic [3:0] wall_bits;
        logic [1:0] heading;
    } item_t;

    typedef struct packed {
        logic [9:0] step_value;
        logic [2:0] move_code;
        logic       queue_overflow;
    } result_t;
endpackage
`default_nettype wire

@@ design/mffp_ram.sv @@
`default_nettype none
module mffp_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);
    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end
endmodule
`default_nettype wire

@@ design/maze_flood_fill_planner_unit.sv @@
`default_nettype none
// Maze flood-fill planner for a 16x16 maze.
// Command channel: raise start with a word on item while busy is low; the
// word is taken at that edge and busy rises. One result word per item comes
// on result with done high for exactly one cycle; busy falls with it.
// Kinds: wall write, flood fill, step read, move choice.
// Config: cfg_we, cfg_index, cfg_data write a register at once; write only
// while busy is low.
// A wall write or a step read passes S_RD, S_RDW, S_FIN and S_OUT; a move
// choice makes four neighbour reads (back, left, right, forward), each an
// S_MREAD and an S_MWAIT, then S_FIN and S_OUT.
// A flood fill clears the distance map cell by cell, seeds the goal cells,
// then works each queued cell: a pop, a fetch of the cell and of its distance
// and walls, and per side a back read, neighbour read, update and settle.
// Every distance read goes through the single read port of the distance RAM.
// One item at a time: the next word may be offered while done is high.
// After reset a pass over every cell sets each distance to 999 and zeroes the
// wall map; busy stays high during it. The receiver cannot stall: done is a
// single-cycle strobe.
module maze_flood_fill_planner_unit (
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             start,
    input  wire mffp_pkg::item_t  item,
    output logic                  busy,
    output logic                  done,
    output mffp_pkg::result_t     result,
    input  wire logic             cfg_we,
    input  wire logic [1:0]       cfg_index,
    input  wire logic [3:0]       cfg_data
);
    import mffp_pkg::*;

    typedef enum logic [15:0] {
        S_INIT    = 16'h0001,
        S_IDLE    = 16'h0002,
        S_CLEAR   = 16'h0004,
        S_SEED    = 16'h0008,
        S_POP     = 16'h0010,
        S_CELL    = 16'h0020,
        S_SIDE    = 16'h0040,
        S_BACK    = 16'h0080,
        S_NEIGH   = 16'h0100,
        S_DECIDE  = 16'h0200,
        S_RD      = 16'h0400,
        S_RDW     = 16'h0800,
        S_MREAD   = 16'h1000,
        S_MWAIT   = 16'h2000,
        S_FIN     = 16'h4000,
        S_OUT     = 16'h8000
    } state_t;

    state_t state_reg, state_next;

    logic [3:0] goal_col_reg, goal_row_reg;
    logic       goal_sq_reg, bias_reg;

    item_t item_reg;
    logic [CELL_BITS-1:0] sweep_reg, sweep_next;     // clear index / seed index
    logic [CELL_BITS-1:0] qhead_reg, qhead_next, qtail_reg, qtail_next;
    logic [QCNT_BITS-1:0] qcnt_reg, qcnt_next;
    logic [POP_BITS:0]    pops_reg, pops_next;
    logic                 ovf_reg, ovf_next;
    logic [CELL_BITS-1:0] cur_reg, cur_next;
    logic [DIST_BITS-1:0] step_reg, step_next;
    logic [3:0]           walls_reg, walls_next;
    logic [1:0]           dir_reg, dir_next;
    logic                 inline_reg, inline_next;
    logic [DIST_BITS-1:0] best_reg, best_next;
    logic [2:0]           code_reg, code_next;
    logic [1:0]           mph_reg, mph_next;         // move phase: back, left, right, fwd
    logic                 first_reg, first_next;
    result_t              res_reg, res_next;
    logic                 done_next;

    // memories
    logic                 dwe, wwe, qwe;
    logic [CELL_BITS-1:0] dwaddr, draddr, wwaddr, wraddr, qwaddr, qraddr;
    logic [DIST_BITS-1:0] dwdata, drdata;
    logic [3:0]           wwdata, wrdata;
    logic [CELL_BITS-1:0] qwdata, qrdata;

    mffp_ram #(.WIDTH(DIST_BITS), .DEPTH(CELLS)) u_dist (
        .clk(clk), .we(dwe), .waddr(dwaddr), .wdata(dwdata), .raddr(draddr), .rdata(drdata));
    mffp_ram #(.WIDTH(4), .DEPTH(CELLS)) u_wall (
        .clk(clk), .we(wwe), .waddr(wwaddr), .wdata(wwdata), .raddr(wraddr), .rdata(wrdata));
    mffp_ram #(.WIDTH(CELL_BITS), .DEPTH(CELLS)) u_queue (
        .clk(clk), .we(qwe), .waddr(qwaddr), .wdata(qwdata), .raddr(qraddr), .rdata(qrdata));

    // neighbour of cell c in direction d; valid flag in the top bit
    function automatic logic [CELL_BITS:0] nb(input logic [CELL_BITS-1:0] c,
                                              input logic [1:0] d);
        logic [SIDE_BITS-1:0] col, row;
        logic ok;
        begin
            col = c[SIDE_BITS-1:0];
            row = c[CELL_BITS-1:SIDE_BITS];
            ok = 1'b1;
            unique case (d)
                2'd0:
                begin
                    ok = (row != {SIDE_BITS{1'b1}});
                    row = row + 1'b1;
                end
                2'd1:
                begin
                    ok = (col != '0);
                    col = col - 1'b1;
                end
                2'd2:
                begin
                    ok = (row != '0);
                    row = row - 1'b1;
                end
                default:
                begin
                    ok = (col != {SIDE_BITS{1'b1}});
                    col = col + 1'b1;
                end
            endcase
            nb = {ok, row, col};
        end
    endfunction

    logic [CELL_BITS-1:0] item_cell;
    assign item_cell = {item_reg.cell_row, item_reg.cell_col};

    logic [CELL_BITS:0] side_nb, back_nb, mv_nb;
    logic [1:0] back_dir, mv_dir;
    assign back_dir = dir_reg + 2'd2;
    assign side_nb = nb(cur_reg, dir_reg);
    assign back_nb = nb(cur_reg, back_dir);

    // move phases: 0 back, 1 left, 2 right, 3 forward
    always_comb
    begin
        unique case (mph_reg)
            2'd0: mv_dir = item_reg.heading + 2'd2;
            2'd1: mv_dir = item_reg.heading + 2'd1;
            2'd2: mv_dir = item_reg.heading + 2'd3;
            default: mv_dir = item_reg.heading;
        endcase
    end
    assign mv_nb = nb(item_cell, mv_dir);

    // seed cell for sweep index 0..3
    logic [4:0] seed_c, seed_r;
    logic       seed_ok;
    always_comb
    begin
        seed_c = {1'b0, goal_col_reg} + {4'd0, sweep_reg[0]};
        seed_r = {1'b0, goal_row_reg} + {4'd0, sweep_reg[1]};
        seed_ok = !seed_c[4] && !seed_r[4] && (goal_sq_reg || sweep_reg[1:0] == 2'd0);
    end

    logic [DIST_BITS:0] val1, val2;
    logic [DIST_BITS-1:0] val_sat;
    assign val1 = {1'b0, step_reg} + 11'd1;
    assign val2 = (bias_reg && !inline_reg) ? {1'b0, step_reg} + 11'd2 : val1;
    assign val_sat = (val2 > {1'b0, MAX_DIST}) ? MAX_DIST : val2[DIST_BITS-1:0];

    always_comb
    begin
        state_next = state_reg;
        sweep_next = sweep_reg;
        qhead_next = qhead_reg;
        qtail_next = qtail_reg;
        qcnt_next = qcnt_reg;
        pops_next = pops_reg;
        ovf_next = ovf_reg;
        cur_next = cur_reg;
        step_next = step_reg;
        walls_next = walls_reg;
        dir_next = dir_reg;
        inline_next = inline_reg;
        best_next = best_reg;
        code_next = code_reg;
        mph_next = mph_reg;
        first_next = first_reg;
        res_next = res_reg;
        done_next = 1'b0;
        dwe = 1'b0;
        dwaddr = sweep_reg;
        dwdata = UNREACHED;
        draddr = item_cell;
        wwe = 1'b0;
        wwaddr = sweep_reg;
        wwdata = '0;
        wraddr = item_cell;
        qwe = 1'b0;
        qwaddr = qtail_reg;
        qwdata = cur_reg;
        qraddr = qhead_reg;

        unique case (state_reg)
            S_INIT:
            begin
                dwe = 1'b1;
                wwe = 1'b1;
                sweep_next = sweep_reg + 1'b1;
                if (sweep_reg == {CELL_BITS{1'b1}})
                begin
                    state_next = S_IDLE;
                end
            end
            S_IDLE:
            begin
                if (start)
                begin
                    sweep_next = '0;
                    unique case (item.kind)
                        KIND_FILL:
                        begin
                            qhead_next = '0;
                            qtail_next = '0;
                            qcnt_next = '0;
                            pops_next = '0;
                            ovf_next = 1'b0;
                            state_next = S_CLEAR;
                        end
                        KIND_MOVE:
                        begin
                            mph_next = 2'd0;
                            code_next = MOVE_ABOUT;
                            state_next = S_MREAD;
                        end
                        default: state_next = S_RD;
                    endcase
                end
            end
            S_CLEAR:
            begin
                dwe = 1'b1;
                sweep_next = sweep_reg + 1'b1;
                if (sweep_reg == {CELL_BITS{1'b1}})
                begin
                    state_next = S_SEED;
                end
            end
            S_SEED:
            begin
                if (seed_ok)
                begin
                    dwe = 1'b1;
                    dwaddr = {seed_r[3:0], seed_c[3:0]};
                    dwdata = '0;
                    qwe = 1'b1;
                    qwdata = {seed_r[3:0], seed_c[3:0]};
                    qtail_next = qtail_reg + 1'b1;
                    qcnt_next = qcnt_reg + 1'b1;
                end
                sweep_next = sweep_reg + 1'b1;
                if (sweep_reg[1:0] == 2'd3)
                begin
                    state_next = S_POP;
                end
            end
            S_POP:
            begin
                // qraddr = head; data next cycle in S_CELL
                if (qcnt_reg == '0)
                begin
                    state_next = S_FIN;
                end
                else if (pops_reg == (POP_BITS+1)'(CELLS * 16))
                begin
                    ovf_next = 1'b1;
                    state_next = S_FIN;
                end
                else
                begin
                    pops_next = pops_reg + 1'b1;
                    qhead_next = qhead_reg + 1'b1;
                    qcnt_next = qcnt_reg - 1'b1;
                    first_next = 1'b1;
                    state_next = S_CELL;
                end
            end
            S_CELL:
            begin
                // first pass: capture the popped cell from the queue; second: address its distance and walls
                if (first_reg)
                begin
                    cur_next = qrdata;
                    first_next = 1'b0;
                end
                else
                begin
                    draddr = cur_reg;
                    wraddr = cur_reg;
                    first_next = 1'b1;
                    if (!first_reg && dir_reg == 2'd0 && first_reg == 1'b0)
                    begin
                        state_next = S_SIDE;
                    end
                end
                dir_next = 2'd0;
            end
            S_SIDE:
            begin
                // data for cur valid here on the first entry from S_CELL
                if (first_reg)
                begin
                    step_next = drdata;
                    walls_next = wrdata;
                    first_next = 1'b0;
                end
                // issue back read for current dir
                draddr = back_nb[CELL_BITS-1:0];
                state_next = S_BACK;
            end
            S_BACK:
            begin
                inline_next = 1'b0;
                if (!walls_reg[back_dir] && back_nb[CELL_BITS])
                begin
                    inline_next = (step_reg >= 10'd1 && drdata == step_reg - 10'd1) ||
                                  (step_reg >= 10'd2 && drdata == step_reg - 10'd2);
                end
                draddr = side_nb[CELL_BITS-1:0];
                state_next = S_NEIGH;
            end
            S_NEIGH:
            begin
                state_next = S_DECIDE;
                if (!walls_reg[dir_reg] && side_nb[CELL_BITS] && {1'b0, drdata} > val1)
                begin
                    dwe = 1'b1;
                    dwaddr = side_nb[CELL_BITS-1:0];
                    dwdata = val_sat;
                    if (qcnt_reg == QCNT_BITS'(CELLS))
                    begin
                        ovf_next = 1'b1;
                    end
                    else
                    begin
                        qwe = 1'b1;
                        qwdata = side_nb[CELL_BITS-1:0];
                        qtail_next = qtail_reg + 1'b1;
                        qcnt_next = qcnt_reg + 1'b1;
                    end
                end
            end
            S_DECIDE:
            begin
                // write of previous side settles before the next read
                if (dir_reg == 2'd3)
                begin
                    state_next = S_POP;
                end
                else
                begin
                    dir_next = dir_reg + 1'b1;
                    state_next = S_SIDE;
                end
                draddr = back_nb[CELL_BITS-1:0];
            end
            S_RD:
            begin
                if (item_reg.kind == KIND_WALLS)
                begin
                    wwe = 1'b1;
                    wwaddr = item_cell;
                    wwdata = item_reg.wall_bits;
                end
                state_next = S_RDW;
            end
            S_RDW:
            begin
                state_next = S_FIN;
            end
            S_MREAD:
            begin
                draddr = mv_nb[CELL_BITS-1:0];
                state_next = S_MWAIT;
            end
            S_MWAIT:
            begin
                unique case (mph_reg)
                    2'd0:
                    begin
                        best_next = mv_nb[CELL_BITS] ? drdata : NO_CELL;
                        if (wrdata[item_reg.heading] && wrdata[item_reg.heading + 2'd1] &&
                            wrdata[item_reg.heading + 2'd3])
                        begin
                            code_next = MOVE_BACKUP;
                        end
                    end
                    default:
                    begin
                        if (mv_nb[CELL_BITS] && !wrdata[mv_dir] && drdata <= best_reg)
                        begin
                            best_next = drdata;
                            code_next = (mph_reg == 2'd1) ? MOVE_LEFT :
                                        (mph_reg == 2'd2) ? MOVE_RIGHT : MOVE_FWD;
                        end
                    end
                endcase
                mph_next = mph_reg + 1'b1;
                state_next = (mph_reg == 2'd3) ? S_FIN : S_MREAD;
            end
            S_FIN:
            begin
                draddr = item_cell;
                state_next = S_OUT;
            end
            S_OUT:
            begin
                res_next.step_value = drdata;
                res_next.move_code = (item_reg.kind == KIND_MOVE) ? code_reg : MOVE_FWD;
                res_next.queue_overflow = ovf_reg;
                done_next = 1'b1;
                state_next = S_IDLE;
            end
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_INIT;
            goal_col_reg <= 4'd7;
            goal_row_reg <= 4'd7;
            goal_sq_reg <= 1'b1;
            bias_reg <= 1'b0;
            sweep_reg <= '0;
            qhead_reg <= '0;
            qtail_reg <= '0;
            qcnt_reg <= '0;
            pops_reg <= '0;
            ovf_reg <= 1'b0;
            mph_reg <= '0;
            first_reg <= 1'b0;
            dir_reg <= '0;
            done <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            sweep_reg <= sweep_next;
            qhead_reg <= qhead_next;
            qtail_reg <= qtail_next;
            qcnt_reg <= qcnt_next;
            pops_reg <= pops_next;
            ovf_reg <= ovf_next;
            mph_reg <= mph_next;
            first_reg <= first_next;
            dir_reg <= dir_next;
            done <= done_next;
            if (cfg_we)
            begin
                unique case (cfg_index)
                    REG_GOAL_COL: goal_col_reg <= cfg_data;
                    REG_GOAL_ROW: goal_row_reg <= cfg_data;
                    REG_GOAL_SQ:  goal_sq_reg <= cfg_data[0];
                    REG_BIAS:     bias_reg <= cfg_data[0];
                    default:      goal_col_reg <= goal_col_reg;
                endcase
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (state_reg == S_IDLE && start)
        begin
            item_reg <= item;
        end
        cur_reg <= cur_next;
        step_reg <= step_next;
        walls_reg <= walls_next;
        inline_reg <= inline_next;
        best_reg <= best_next;
        code_reg <= code_next;
        res_reg <= res_next;
    end

    assign busy = (state_reg != S_IDLE);
    assign result = res_reg;
endmodule
`default_nettype wire

@@ tb/tb.sv @@
`timescale 1ns / 1ps
`default_nettype none
module tb;
    import mffp_pkg::*;

    localparam int CYCLE_LIMIT = 10_000_000;

    // Planner model: own copy of walls, distances and registers
    class plan_board;
        logic [3:0] walls [256];
        logic [9:0] dmap [256];
        logic [3:0] g_col, g_row;
        logic       g_sq, bias;
        logic       ovf;
        result_t    pending [$];
        int         errors;

        function void clear_all();
            for (int i = 0; i < 256; i++)
            begin
                walls[i] = 4'd0;
                dmap[i] = UNREACHED;
            end
            g_col = 4'd7;
            g_row = 4'd7;
            g_sq = 1'b1;
            bias = 1'b0;
            ovf = 1'b0;
            errors = 0;
        endfunction

        function void set_reg(logic [1:0] idx, logic [3:0] val);
            case (idx)
                REG_GOAL_COL: g_col = val;
                REG_GOAL_ROW: g_row = val;
                REG_GOAL_SQ:  g_sq = val[0];
                REG_BIAS:     bias = val[0];
                default: ;
            endcase
        endfunction

        // neighbour cell index, -1 off the edge; dir 0 N, 1 W, 2 S, 3 E
        function int nbr(int idx, int dir);
            int c, r;
            c = idx % 16;
            r = idx / 16;
            case (dir & 3)
                0: r = r + 1;
                1: c = c - 1;
                2: r = r - 1;
                default: c = c + 1;
            endcase
            if (c < 0 || r < 0 || c > 15 || r > 15)
                return -1;
            return r * 16 + c;
        endfunction

        function void fill_distances();
            int q [$];
            int pops, idx, n, m, bd, step, val;
            bit in_line;
            for (int i = 0; i < 256; i++)
                dmap[i] = UNREACHED;
            ovf = 1'b0;
            pops = 0;
            for (int k = 0; k < (g_sq ? 4 : 1); k++)
            begin
                int c, r;
                c = int'(g_col) + (k & 1);
                r = int'(g_row) + (k >> 1);
                if (c <= 15 && r <= 15)
                begin
                    dmap[r * 16 + c] = 10'd0;
                    q.push_back(r * 16 + c);
                end
            end
            while (q.size() > 0)
            begin
                if (pops >= 4096)
                begin
                    ovf = 1'b1;
                    break;
                end
                pops++;
                idx = q.pop_front();
                step = dmap[idx];
                for (int d = 0; d < 4; d++)
                begin
                    n = nbr(idx, d);
                    if (walls[idx][d] || n < 0 || !(int'(dmap[n]) > step + 1))
                        continue;
                    val = step + 1;
                    if (bias)
                    begin
                        bd = (d + 2) & 3;
                        m = nbr(idx, bd);
                        in_line = 0;
                        if (!walls[idx][bd] && m >= 0)
                            if ((step >= 1 && int'(dmap[m]) == step - 1) ||
                                (step >= 2 && int'(dmap[m]) == step - 2))
                                in_line = 1;
                        if (!in_line)
                            val = step + 2;
                    end
                    if (val > 998)
                        val = 998;
                    dmap[n] = val[9:0];
                    if (q.size() >= 256)
                        ovf = 1'b1;
                    else
                        q.push_back(n);
                end
            end
        endfunction

        function logic [2:0] pick_move(int idx, int h);
            int fw, lf, rt, bk, n;
            int best;
            logic [2:0] code;
            logic [3:0] w;
            fw = h & 3;
            lf = (h + 1) & 3;
            rt = (h + 3) & 3;
            bk = (h + 2) & 3;
            w = walls[idx];
            code = (w[fw] && w[lf] && w[rt]) ? MOVE_BACKUP : MOVE_ABOUT;
            n = nbr(idx, bk);
            best = (n >= 0) ? int'(dmap[n]) : int'(NO_CELL);
            n = nbr(idx, lf);
            if (n >= 0 && !w[lf] && int'(dmap[n]) <= best)
            begin
                code = MOVE_LEFT;
                best = dmap[n];
            end
            n = nbr(idx, rt);
            if (n >= 0 && !w[rt] && int'(dmap[n]) <= best)
            begin
                code = MOVE_RIGHT;
                best = dmap[n];
            end
            n = nbr(idx, fw);
            if (n >= 0 && !w[fw] && int'(dmap[n]) <= best)
                code = MOVE_FWD;
            return code;
        endfunction

        function void note_item(item_t it);
            result_t r;
            int idx;
            idx = int'(it.cell_row) * 16 + int'(it.cell_col);
            r.move_code = MOVE_FWD;
            case (it.kind)
                KIND_WALLS: walls[idx] = it.wall_bits;
                KIND_FILL:  fill_distances();
                KIND_MOVE:  r.move_code = pick_move(idx, it.heading);
                default: ;
            endcase
            r.step_value = dmap[idx];
            r.queue_overflow = ovf;
            pending.push_back(r);
        endfunction

        task report(string what, int got, int want);
            $display("mismatch %s: got %0d expected %0d", what, got, want);
            errors++;
        endtask

        task check_word(result_t got);
            result_t want;
            if (pending.size() == 0)
            begin
                report("unexpected word", 1, 0);
                return;
            end
            want = pending.pop_front();
            if (got.step_value !== want.step_value)
                report("step_value", got.step_value, want.step_value);
            if (got.move_code !== want.move_code)
                report("move_code", got.move_code, want.move_code);
            if (got.queue_overflow !== want.queue_overflow)
                report("queue_overflow", got.queue_overflow, want.queue_overflow);
        endtask
    endclass

    logic       clk;
    logic       rst_n;
    logic       start;
    item_t      item;
    logic       busy;
    logic       done;
    result_t    result;
    logic       cfg_we;
    logic [1:0] cfg_index;
    logic [3:0] cfg_data;

    plan_board board;
    int        idle_pct;
    longint    cycles = 0;

    maze_flood_fill_planner_unit dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (start),
        .item      (item),
        .busy      (busy),
        .done      (done),
        .result    (result),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (rst_n && done)
            board.check_word(result);
        if (cycles > CYCLE_LIMIT)
        begin
            $display("[maze_flood_fill_planner_unit] ERROR");
            $finish;
        end
    end

    task automatic send_word(item_t it);
        while ($urandom_range(99) < idle_pct)
            @(posedge clk);
        start <= 1'b1;
        item <= it;
        @(posedge clk);
        while (busy)
            @(posedge clk);
        board.note_item(it);
        start <= 1'b0;
        // wait for the answer so busy is seen high before the next word
        while (board.pending.size() > 0)
            @(posedge clk);
    endtask

    task automatic send_fields(logic [1:0] k, int c, int r, int w, int h);
        item_t it;
        it.kind = k;
        it.cell_col = c[3:0];
        it.cell_row = r[3:0];
        it.wall_bits = w[3:0];
        it.heading = h[1:0];
        send_word(it);
    endtask

    task automatic write_reg(logic [1:0] idx, logic [3:0] val);
        // let any trailing work settle first
        repeat (40) @(posedge clk);
        while (busy)
            @(posedge clk);
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
        @(posedge clk);
        cfg_we <= 1'b0;
        board.set_reg(idx, val);
    endtask

    task automatic set_goal(int c, int r, int sq, int b);
        write_reg(REG_GOAL_COL, c[3:0]);
        write_reg(REG_GOAL_ROW, r[3:0]);
        write_reg(REG_GOAL_SQ, sq[3:0]);
        write_reg(REG_BIAS, b[3:0]);
    endtask

    // random walls mostly, fills now and then, reads and moves
    task automatic random_phase(int n);
        int k;
        for (int i = 0; i < n; i++)
        begin
            k = $urandom_range(99);
            if (k < 45)
                send_fields(KIND_WALLS, $urandom_range(15), $urandom_range(15),
                            ($urandom_range(3) == 0) ? 0 : $urandom_range(15), 0);
            else if (k < 52)
                send_fields(KIND_FILL, $urandom_range(15), $urandom_range(15),
                            $urandom_range(15), $urandom_range(3));
            else if (k < 70)
                send_fields(KIND_READ, $urandom_range(15), $urandom_range(15),
                            $urandom_range(15), $urandom_range(3));
            else
                send_fields(KIND_MOVE, $urandom_range(15), $urandom_range(15),
                            $urandom_range(15), $urandom_range(3));
        end
    endtask

    initial
    begin
        board = new();
        board.clear_all();
        idle_pct = 0;
        rst_n = 1'b0;
        start = 1'b0;
        item = '0;
        cfg_we = 1'b0;
        cfg_index = REG_GOAL_COL;
        cfg_data = 4'd0;
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed: reads before any fill, corners, every kind and heading
        send_fields(KIND_READ, 0, 0, 0, 0);
        send_fields(KIND_MOVE, 15, 15, 15, 3);
        send_fields(KIND_FILL, 0, 0, 0, 0);
        send_fields(KIND_READ, 7, 7, 0, 0);
        send_fields(KIND_READ, 15, 15, 0, 0);
        send_fields(KIND_WALLS, 3, 3, 15, 0);
        send_fields(KIND_WALLS, 3, 4, 7, 0);
        send_fields(KIND_WALLS, 0, 0, 10, 0);
        send_fields(KIND_WALLS, 15, 15, 5, 0);
        send_fields(KIND_FILL, 15, 15, 15, 3);
        for (int h = 0; h < 4; h++)
            send_fields(KIND_MOVE, 3, 3, 0, h);
        send_fields(KIND_MOVE, 3, 4, 0, 2);
        send_fields(KIND_MOVE, 0, 0, 0, 1);
        send_fields(KIND_MOVE, 15, 15, 0, 0);
        send_fields(KIND_READ, 3, 3, 0, 0);

        // goal at the far corner, partly outside; single goal with bias
        set_goal(15, 15, 1, 1);
        send_fields(KIND_FILL, 0, 0, 0, 0);
        send_fields(KIND_READ, 0, 0, 0, 0);
        send_fields(KIND_MOVE, 1, 1, 0, 0);
        set_goal(0, 0, 0, 1);
        send_fields(KIND_FILL, 0, 0, 0, 0);
        send_fields(KIND_READ, 15, 15, 0, 0);
        send_fields(KIND_MOVE, 8, 8, 0, 3);

        random_phase(70);
        idle_pct = 71;
        set_goal($urandom_range(15), $urandom_range(15), 0, 0);
        random_phase(70);
        idle_pct = 13;
        set_goal(7, 7, 1, 1);
        random_phase(70);
        idle_pct = 0;
        set_goal(15, 0, 1, 0);
        random_phase(55);

        repeat (40) @(posedge clk);
        if (board.errors == 0 && board.pending.size() == 0)
            $display("[maze_flood_fill_planner_unit] OK");
        else
            $display("[maze_flood_fill_planner_unit] ERROR");
        $finish;
    end
endmodule

@@ maze_flood_fill_planner_unit.f @@
design/mffp_pkg.sv
design/mffp_ram.sv
design/maze_flood_fill_planner_unit.sv
tb/tb.sv
